// ===== rtl/tarhc_pkg.sv =====
// ----------------------------------------------------------------------------
// tarhc_pkg
// Shared types, constants and the octal field scanner for the ustar header
// checker.
// ----------------------------------------------------------------------------
package tarhc_pkg;

	localparam int BLOCK_BYTES = 512;
	localparam int POS_W       = $clog2(BLOCK_BYTES);
	localparam int SUM_W       = 17;
	localparam int SIZE_W      = 36;
	localparam int CSUM_W      = 24;
	localparam int BLOCKS_W    = 28;
	localparam int BLK_SHIFT   = $clog2(BLOCK_BYTES);

	localparam logic [POS_W-1:0] SUM_FIRST   = POS_W'(148);
	localparam logic [POS_W-1:0] SUM_LAST    = POS_W'(155);
	localparam logic [POS_W-1:0] SIZE_FIRST  = POS_W'(124);
	localparam logic [POS_W-1:0] SIZE_LAST   = POS_W'(135);
	localparam logic [POS_W-1:0] LAST_OFFSET = POS_W'(BLOCK_BYTES - 1);
	localparam logic [SUM_W-1:0] SPACE_FILL  = SUM_W'(8 * 32);

	// octal scan phase
	localparam logic [1:0] PH_SKIP   = 2'd0;
	localparam logic [1:0] PH_DIGITS = 2'd1;
	localparam logic [1:0] PH_DONE   = 2'd2;

	// result status
	localparam logic [1:0] STATUS_VALID    = 2'd0;
	localparam logic [1:0] STATUS_EOA      = 2'd1;
	localparam logic [1:0] STATUS_MISMATCH = 2'd2;

	typedef struct packed {
		logic [1:0]        phase;
		logic [SIZE_W-1:0] value;
	} octal_t;

	// Header state as seen by the result logic
	typedef struct packed {
		logic [POS_W-1:0]  pos;
		logic              last;
		logic [SUM_W-1:0]  running_sum;
		logic [1:0]        name_zero;
		logic [SIZE_W-1:0] size_value;
		logic [CSUM_W-1:0] csum_value;
	} scan_state_t;

	// One character of a %o style scan. Narrower fields truncate the result.
	function automatic octal_t octal_step(input logic [1:0] phase,
			input logic [SIZE_W-1:0] value, input logic [7:0] c);
		octal_t r;
		logic   digit;
		logic   blank;
		r.phase = phase;
		r.value = value;
		digit   = (c >= 8'h30) && (c <= 8'h37);
		blank   = (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0d));
		unique case (phase)
			PH_SKIP: begin
				if (!blank) begin
					if (digit) begin
						r.phase = PH_DIGITS;
						r.value = {{(SIZE_W-3){1'b0}}, c[2:0]};
					end else begin
						// sign or other junk: value is zero
						r.phase = PH_DONE;
						r.value = '0;
					end
				end
			end
			PH_DIGITS: begin
				if (digit) begin
					r.value = {value[SIZE_W-4:0], c[2:0]};
				end else begin
					r.phase = PH_DONE;
				end
			end
			default: begin
			end
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/tarhc_scan.sv =====
// ----------------------------------------------------------------------------
// tarhc_scan
// Per-header running state: byte offset, byte sum, name start check and the
// octal scanners for the size and checksum fields. Clears after the last byte.
// ----------------------------------------------------------------------------
module tarhc_scan (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step_en,
	input  logic [7:0]           hdr_byte,
	output tarhc_pkg::scan_state_t state
);

	logic [tarhc_pkg::POS_W-1:0]  pos_q;
	logic [tarhc_pkg::SUM_W-1:0]  sum_q;
	logic [1:0]                   name_zero_q;
	logic [tarhc_pkg::SIZE_W-1:0] size_q;
	logic [1:0]                   size_ph_q;
	logic [tarhc_pkg::CSUM_W-1:0] csum_q;
	logic [1:0]                   csum_ph_q;

	logic              in_csum;
	logic              in_size;
	logic              last;
	tarhc_pkg::octal_t size_nxt;
	tarhc_pkg::octal_t csum_nxt;

	assign in_csum = (pos_q >= tarhc_pkg::SUM_FIRST) && (pos_q <= tarhc_pkg::SUM_LAST);
	assign in_size = (pos_q >= tarhc_pkg::SIZE_FIRST) && (pos_q <= tarhc_pkg::SIZE_LAST);
	assign last    = (pos_q == tarhc_pkg::LAST_OFFSET);

	assign size_nxt = tarhc_pkg::octal_step(size_ph_q, size_q, hdr_byte);
	assign csum_nxt = tarhc_pkg::octal_step(csum_ph_q,
		{{(tarhc_pkg::SIZE_W-tarhc_pkg::CSUM_W){1'b0}}, csum_q}, hdr_byte);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			sum_q       <= '0;
			name_zero_q <= '0;
			size_q      <= '0;
			size_ph_q   <= tarhc_pkg::PH_SKIP;
			csum_q      <= '0;
			csum_ph_q   <= tarhc_pkg::PH_SKIP;
		end else if (step_en) begin
			if (last) begin
				pos_q       <= '0;
				sum_q       <= '0;
				name_zero_q <= '0;
				size_q      <= '0;
				size_ph_q   <= tarhc_pkg::PH_SKIP;
				csum_q      <= '0;
				csum_ph_q   <= tarhc_pkg::PH_SKIP;
			end else begin
				pos_q <= pos_q + 1'b1;
				if (hdr_byte == 8'd0 && pos_q == '0) begin
					name_zero_q[0] <= 1'b1;
				end
				if (hdr_byte == 8'd0 && pos_q == tarhc_pkg::POS_W'(1)) begin
					name_zero_q[1] <= 1'b1;
				end
				if (in_csum) begin
					csum_q    <= csum_nxt.value[tarhc_pkg::CSUM_W-1:0];
					csum_ph_q <= csum_nxt.phase;
				end else begin
					sum_q <= sum_q + tarhc_pkg::SUM_W'(hdr_byte);
				end
				if (in_size) begin
					size_q    <= size_nxt.value;
					size_ph_q <= size_nxt.phase;
				end
			end
		end
	end

	always_comb begin
		state.pos         = pos_q;
		state.last        = last;
		state.running_sum = sum_q;
		state.name_zero   = name_zero_q;
		state.size_value  = size_q;
		state.csum_value  = csum_q;
	end

endmodule

// ===== rtl/tar_header_checker.sv =====
// ----------------------------------------------------------------------------
// tar_header_checker
// Checks one 512-byte ustar header per result: byte sum against the octal
// checksum field, end-of-archive detection, and the octal size field.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+--------------------------------
//  in       | sink      | in_valid / in_stall | hdr_byte
//  out      | source    | out_valid/out_stall | status, file_size, data_blocks,
//           |           |                     | computed_sum, stored_sum
//
//  One header byte per cycle while in_stall is low.
//  Each byte is held in the input register; the result register loads
//  as the last byte steps on out of it, so the result sits behind both.
//  Reset clears the offset, sums, scanners and both valid flags.
//  in_stall rises only when the last byte of a header waits on a result
//  that is still held by out_stall.
// ----------------------------------------------------------------------------
module tar_header_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [7:0]                         hdr_byte,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [1:0]                         status,
	output logic [tarhc_pkg::SIZE_W-1:0]       file_size,
	output logic [tarhc_pkg::BLOCKS_W-1:0]     data_blocks,
	output logic [tarhc_pkg::SUM_W-1:0]        computed_sum,
	output logic [tarhc_pkg::CSUM_W-1:0]       stored_sum
);

	logic                                  valid_s1;
	logic [7:0]                            byte_s1;
	logic                                  out_valid_q;
	logic [1:0]                            status_q;
	logic [tarhc_pkg::SIZE_W-1:0]          size_q;
	logic [tarhc_pkg::BLOCKS_W-1:0]        blocks_q;
	logic [tarhc_pkg::SUM_W-1:0]           comp_q;
	logic [tarhc_pkg::CSUM_W-1:0]          stored_q;

	tarhc_pkg::scan_state_t                scan;
	logic                                  advance;
	logic                                  step_en;
	logic                                  load_result;
	logic                                  in_accept;
	logic [tarhc_pkg::SUM_W-1:0]           comp_nxt;
	logic [tarhc_pkg::SIZE_W:0]            round_up;
	logic [1:0]                            status_nxt;

	// the last byte can only move on if the result register is free
	assign advance     = !scan.last || !out_valid_q || !out_stall;
	assign in_stall    = valid_s1 && !advance;
	assign in_accept   = in_valid && !in_stall;
	assign step_en     = valid_s1 && advance;
	assign load_result = step_en && scan.last;

	tarhc_scan u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.step_en  (step_en),
		.hdr_byte (byte_s1),
		.state    (scan)
	);

	// last byte is outside both fields, so it only joins the sum
	assign comp_nxt = scan.running_sum + tarhc_pkg::SUM_W'(byte_s1) + tarhc_pkg::SPACE_FILL;
	assign round_up = {1'b0, scan.size_value} + (tarhc_pkg::SIZE_W+1)'(tarhc_pkg::BLOCK_BYTES - 1);

	always_comb begin
		if (scan.name_zero == 2'b11) begin
			status_nxt = tarhc_pkg::STATUS_EOA;
		end else if ({{(tarhc_pkg::CSUM_W-tarhc_pkg::SUM_W){1'b0}}, comp_nxt} != scan.csum_value) begin
			status_nxt = tarhc_pkg::STATUS_MISMATCH;
		end else begin
			status_nxt = tarhc_pkg::STATUS_VALID;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			byte_s1 <= hdr_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_result) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_result) begin
			status_q <= status_nxt;
			size_q   <= scan.size_value;
			blocks_q <= round_up[tarhc_pkg::SIZE_W:tarhc_pkg::BLK_SHIFT];
			comp_q   <= comp_nxt;
			stored_q <= scan.csum_value;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign file_size    = size_q;
	assign data_blocks  = blocks_q;
	assign computed_sum = comp_q;
	assign stored_sum   = stored_q;

	// a new result only follows the last byte of a header
	a_rise_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(valid_s1 && scan.last))
		else $error("result without last header byte");

	// the input side only waits on a held result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (scan.last && out_valid_q && out_stall))
		else $error("input stalled without a held result");

	// offset wraps to zero once a header is done
	a_pos_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		load_result |=> (scan.pos == '0 && scan.name_zero == 2'b00))
		else $error("header state not cleared after result");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (status_q != 2'd3))
		else $error("undefined status code");

endmodule

// ===== tb/sv/tar_header_checker_test.sv =====
// ----------------------------------------------------------------------------
// tar_header_checker_test
// Streams 512-byte ustar headers into the checker one request per byte and
// checks every result against a byte-level scoreboard: byte sum, octal size
// and checksum fields, block count and status. Covers directed corner
// headers, random headers, a long result hold-off and a full-rate stream.
// ----------------------------------------------------------------------------
module tar_header_checker_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SIZE_W   = tarhc_pkg::SIZE_W;
	localparam int SUM_W    = tarhc_pkg::SUM_W;
	localparam int CSUM_W   = tarhc_pkg::CSUM_W;
	localparam int BLOCKS_W = tarhc_pkg::BLOCKS_W;

	localparam logic [1:0] PH_SKIP         = tarhc_pkg::PH_SKIP;
	localparam logic [1:0] PH_DIGITS       = tarhc_pkg::PH_DIGITS;
	localparam logic [1:0] PH_DONE         = tarhc_pkg::PH_DONE;
	localparam logic [1:0] STATUS_VALID    = tarhc_pkg::STATUS_VALID;
	localparam logic [1:0] STATUS_EOA      = tarhc_pkg::STATUS_EOA;
	localparam logic [1:0] STATUS_MISMATCH = tarhc_pkg::STATUS_MISMATCH;

	localparam int CYCLE_LIMIT  = 3_000_000;
	localparam int DRAIN_CYCLES = 16;
	localparam int HDR_BYTES    = 512;
	localparam int SIZE_AT      = 124;
	localparam int SIZE_LEN     = 12;
	localparam int CSUM_AT      = 148;
	localparam int CSUM_LEN     = 8;

	localparam logic [7:0] NUL   = 8'h00;
	localparam logic [7:0] SPACE = 8'h20;
	localparam logic [7:0] PLUS  = 8'h2b;
	localparam logic [7:0] MINUS = 8'h2d;
	localparam logic [7:0] ZERO  = 8'h30;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic [7:0]          hdr_byte;
	logic                out_valid;
	logic                out_stall;
	logic [1:0]          status;
	logic [SIZE_W-1:0]   file_size;
	logic [BLOCKS_W-1:0] data_blocks;
	logic [SUM_W-1:0]    computed_sum;
	logic [CSUM_W-1:0]   stored_sum;

	tar_header_checker dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.hdr_byte     (hdr_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.file_size    (file_size),
		.data_blocks  (data_blocks),
		.computed_sum (computed_sum),
		.stored_sum   (stored_sum)
	);

	typedef struct packed {
		logic [1:0]          status;
		logic [SIZE_W-1:0]   file_size;
		logic [BLOCKS_W-1:0] data_blocks;
		logic [SUM_W-1:0]    computed_sum;
		logic [CSUM_W-1:0]   stored_sum;
	} header_result_t;

	typedef struct packed {
		logic [1:0]        phase;
		logic [SIZE_W-1:0] value;
	} field_scan_t;

	// scoreboard state
	logic [8:0]       byte_offset;
	logic [SUM_W-1:0] byte_sum;
	logic [1:0]       name_nul;
	field_scan_t      size_scan;
	field_scan_t      csum_scan;
	header_result_t   expected_results[$];

	int  mismatches      = 0;
	int  headers_checked = 0;
	int  cycle_count     = 0;
	int  hold_off_cycles = 0;
	bit  sender_idle     = 1'b1;
	bit  receiver_idle   = 1'b1;

	logic [7:0] hdr [HDR_BYTES];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) cycle_count <= cycle_count + 1;

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("FAIL");
		$finish;
	end

	task automatic report_mismatch(string what);
		mismatches++;
		if (mismatches <= 40)
			$display("error: %s", what);
	endtask

	// ---------------------------------------------------------------- scoreboard

	function automatic field_scan_t scan_octal_char(field_scan_t s, logic [7:0] c);
		logic is_digit;
		logic is_blank;
		is_digit = (c >= ZERO) && (c <= 8'h37);
		is_blank = (c == SPACE) || ((c >= 8'h09) && (c <= 8'h0d));
		if (s.phase == PH_SKIP) begin
			if (is_digit) begin
				s.phase = PH_DIGITS;
				s.value = SIZE_W'(c - ZERO);
			end else if (!is_blank) begin
				// sign or junk before any digit: field reads as zero
				s.phase = PH_DONE;
				s.value = '0;
			end
		end else if (s.phase == PH_DIGITS) begin
			if (is_digit)
				s.value = (s.value << 3) | SIZE_W'(c - ZERO);
			else
				s.phase = PH_DONE;
		end
		return s;
	endfunction

	function automatic void clear_header_state();
		byte_offset     = '0;
		byte_sum        = '0;
		name_nul        = '0;
		size_scan.phase = PH_SKIP;
		size_scan.value = '0;
		csum_scan.phase = PH_SKIP;
		csum_scan.value = '0;
	endfunction

	function automatic void absorb_header_byte(logic [7:0] c);
		header_result_t r;
		logic [SIZE_W:0] rounded;
		if (byte_offset == 9'd0 && c == NUL)
			name_nul[0] = 1'b1;
		if (byte_offset == 9'd1 && c == NUL)
			name_nul[1] = 1'b1;
		if (byte_offset >= CSUM_AT && byte_offset < CSUM_AT + CSUM_LEN)
			csum_scan = scan_octal_char(csum_scan, c);
		else
			byte_sum = byte_sum + SUM_W'(c);
		if (byte_offset >= SIZE_AT && byte_offset < SIZE_AT + SIZE_LEN)
			size_scan = scan_octal_char(size_scan, c);

		if (byte_offset != 9'(HDR_BYTES - 1)) begin
			byte_offset = byte_offset + 9'd1;
		end else begin
			// checksum field counts as eight spaces
			r.computed_sum = byte_sum + SUM_W'(8 * 32);
			r.stored_sum   = csum_scan.value[CSUM_W-1:0];
			r.file_size    = size_scan.value;
			rounded        = {1'b0, size_scan.value} + (SIZE_W+1)'(HDR_BYTES - 1);
			r.data_blocks  = BLOCKS_W'(rounded >> 9);
			if (name_nul == 2'b11)
				r.status = STATUS_EOA;
			else if (SIZE_W'(r.computed_sum) != SIZE_W'(r.stored_sum))
				r.status = STATUS_MISMATCH;
			else
				r.status = STATUS_VALID;
			expected_results.push_back(r);
			clear_header_state();
		end
	endfunction

	always @(posedge clk) begin : result_monitor
		header_result_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					report_mismatch($sformatf("result with no header pending, status %0d",
						status));
				end else begin
					want = expected_results.pop_front();
					if (status !== want.status)
						report_mismatch($sformatf("header %0d status: got %0d, want %0d",
							headers_checked, status, want.status));
					if (file_size !== want.file_size)
						report_mismatch($sformatf("header %0d file_size: got %0h, want %0h",
							headers_checked, file_size, want.file_size));
					if (data_blocks !== want.data_blocks)
						report_mismatch($sformatf("header %0d data_blocks: got %0h, want %0h",
							headers_checked, data_blocks, want.data_blocks));
					if (computed_sum !== want.computed_sum)
						report_mismatch($sformatf("header %0d computed_sum: got %0h, want %0h",
							headers_checked, computed_sum, want.computed_sum));
					if (stored_sum !== want.stored_sum)
						report_mismatch($sformatf("header %0d stored_sum: got %0h, want %0h",
							headers_checked, stored_sum, want.stored_sum));
					headers_checked++;
				end
			end
			if (in_valid && !in_stall)
				absorb_header_byte(hdr_byte);
		end
	end

	// ------------------------------------------------------------------ receiver

	initial begin : result_receiver
		int burst;
		out_stall <= 1'b0;
		@(posedge clk);
		forever begin
			if (hold_off_cycles > 0) begin
				out_stall <= 1'b1;
				repeat (hold_off_cycles) @(posedge clk);
				hold_off_cycles = 0;
			end else if (receiver_idle && $urandom_range(0, 11) == 0) begin
				burst = $urandom_range(1, 17);
				out_stall <= 1'b1;
				repeat (burst) @(posedge clk);
			end else begin
				out_stall <= 1'b0;
				@(posedge clk);
			end
		end
	end

	// ---------------------------------------------------------- header building

	function automatic logic [7:0] blank_char(int k);
		case (k % 6)
			0:       return 8'h20;
			1:       return 8'h09;
			2:       return 8'h0a;
			3:       return 8'h0b;
			4:       return 8'h0c;
			default: return 8'h0d;
		endcase
	endfunction

	function automatic int octal_digits(logic [SIZE_W-1:0] v);
		int d;
		d = 1;
		while (d < 12 && (v >> (3 * d)) != 0)
			d++;
		return d;
	endfunction

	function automatic int header_sum();
		int s;
		s = 8 * 32;
		for (int i = 0; i < HDR_BYTES; i++)
			if (i < CSUM_AT || i >= CSUM_AT + CSUM_LEN)
				s += hdr[i];
		return s;
	endfunction

	// blanks, then the low octal digits of value, then a terminator if room
	task automatic put_field(int first, int len, logic [SIZE_W-1:0] value, int lead,
			int digits, logic [7:0] term);
		int p;
		int rot;
		p   = first;
		rot = $urandom_range(0, 5);
		for (int i = 0; i < lead && p < first + len; i++) begin
			hdr[p] = blank_char(i + rot);
			p++;
		end
		for (int d = digits - 1; d >= 0 && p < first + len; d--) begin
			hdr[p] = ZERO + 8'(value[3*d +: 3]);
			p++;
		end
		if (p < first + len)
			hdr[p] = term;
	endtask

	task automatic seal_checksum(int skew);
		logic [SIZE_W-1:0] sum;
		sum = SIZE_W'(header_sum() + skew);
		case ($urandom_range(0, 2))
			0: begin
				put_field(CSUM_AT, CSUM_LEN, sum, 0, 6, NUL);
				hdr[CSUM_AT + 7] = SPACE;
			end
			1:       put_field(CSUM_AT, CSUM_LEN, sum, 0, 7, NUL);
			default: put_field(CSUM_AT, CSUM_LEN, sum, 1, 6, SPACE);
		endcase
	endtask

	task automatic fill_header(logic [7:0] fill);
		for (int i = 0; i < HDR_BYTES; i++)
			hdr[i] = fill;
	endtask

	task automatic fill_random();
		for (int i = 0; i < HDR_BYTES; i++)
			hdr[i] = 8'($urandom);
	endtask

	task automatic make_standard_header(logic [SIZE_W-1:0] size);
		fill_random();
		put_field(SIZE_AT, SIZE_LEN, size, 0, 11, NUL);
		seal_checksum(0);
	endtask

	task automatic make_wellformed_header();
		logic [SIZE_W-1:0] size;
		int digits;
		fill_random();
		case ($urandom_range(0, 3))
			0:       size = SIZE_W'($urandom_range(0, 4096));
			1:       size = SIZE_W'({$urandom, $urandom}) >> $urandom_range(0, 35);
			2:       size = SIZE_W'($urandom_range(1, 64)) * 512
					+ SIZE_W'($urandom_range(0, 2)) - 1;
			default: size = SIZE_W'({$urandom, $urandom});
		endcase
		digits = octal_digits(size);
		if (digits == 12)
			put_field(SIZE_AT, SIZE_LEN, size, 0, 12, NUL);
		else if ($urandom_range(0, 1) == 1)
			put_field(SIZE_AT, SIZE_LEN, size, 0, 11, NUL);
		else
			put_field(SIZE_AT, SIZE_LEN, size, $urandom_range(0, 11 - digits), digits, SPACE);
		if ($urandom_range(0, 9) == 0) begin
			hdr[0] = NUL;
			hdr[1] = NUL;
		end
		seal_checksum(($urandom_range(0, 5) == 0) ? $urandom_range(1, 40) : 0);
	endtask

	task automatic break_field();
		int at;
		at = ($urandom_range(0, 1) == 1) ? SIZE_AT : CSUM_AT;
		case ($urandom_range(0, 3))
			0:       hdr[at] = ($urandom_range(0, 1) == 1) ? PLUS : MINUS;
			1:       hdr[at] = ($urandom_range(0, 1) == 1) ? 8'h38 + 8'($urandom_range(0, 1))
					: 8'($urandom);
			2:       hdr[at + $urandom_range(0, 7)] = 8'($urandom);
			default: for (int i = 0; i < CSUM_LEN; i++) hdr[at + i] = NUL;
		endcase
	endtask

	// ------------------------------------------------------------------ sender

	task automatic send_byte(logic [7:0] b);
		int gap;
		if (sender_idle && $urandom_range(0, 11) == 0) begin
			gap = $urandom_range(1, 17);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		hdr_byte <= b;
		do
			@(posedge clk);
		while (in_stall);
	endtask

	task automatic send_header();
		for (int i = 0; i < HDR_BYTES; i++)
			send_byte(hdr[i]);
	endtask

	// ------------------------------------------------------------------- tests

	task automatic test_directed_headers();
		logic [SIZE_W-1:0] sum;
		// all-zero block marks end of archive
		fill_header(NUL);
		send_header();
		make_standard_header(SIZE_W'(1000));
		send_header();
		// twelve sevens: largest size, block count needs the top bit
		fill_random();
		put_field(SIZE_AT, SIZE_LEN, '1, 0, 12, NUL);
		seal_checksum(0);
		send_header();
		make_standard_header('0);
		send_header();
		make_standard_header(SIZE_W'(512));
		send_header();
		make_standard_header(SIZE_W'(513));
		send_header();
		// every byte 0xff: largest sum, both fields junk
		fill_header(8'hff);
		send_header();
		make_standard_header(SIZE_W'('o777));
		seal_checksum(1);
		send_header();
		// end of archive wins over a bad sum
		make_standard_header(SIZE_W'(77));
		hdr[0] = NUL;
		hdr[1] = NUL;
		seal_checksum(5);
		send_header();
		make_standard_header(SIZE_W'(77));
		hdr[0] = NUL;
		hdr[1] = 8'h41;
		seal_checksum(0);
		send_header();
		make_standard_header(SIZE_W'(77));
		hdr[0] = 8'h41;
		hdr[1] = NUL;
		seal_checksum(0);
		send_header();
		// all six blank kinds ahead of the size digits
		fill_random();
		put_field(SIZE_AT, SIZE_LEN, SIZE_W'('o4321), 6, 4, SPACE);
		sum = SIZE_W'(header_sum());
		put_field(CSUM_AT, CSUM_LEN, sum, 1, 6, SPACE);
		send_header();
		// leading signs
		make_standard_header(SIZE_W'('o1234));
		hdr[SIZE_AT] = PLUS;
		seal_checksum(0);
		hdr[CSUM_AT] = MINUS;
		send_header();
		make_standard_header(SIZE_W'(100));
		hdr[SIZE_AT]     = SPACE;
		hdr[SIZE_AT + 1] = MINUS;
		seal_checksum(0);
		hdr[CSUM_AT] = PLUS;
		send_header();
		// no digits at all
		fill_random();
		for (int i = 0; i < SIZE_LEN; i++)
			hdr[SIZE_AT + i] = SPACE;
		for (int i = 0; i < CSUM_LEN; i++)
			hdr[CSUM_AT + i] = NUL;
		send_header();
		// '8' ends a digit run; junk first in the checksum
		make_standard_header('0);
		put_field(SIZE_AT, SIZE_LEN, SIZE_W'('o17), 0, 2, 8'h38);
		seal_checksum(0);
		hdr[CSUM_AT] = 8'h41;
		send_header();
		// blank after digits ends the field
		make_standard_header('0);
		put_field(SIZE_AT, SIZE_LEN, SIZE_W'('o12), 0, 2, SPACE);
		hdr[SIZE_AT + 3] = 8'h33;
		seal_checksum(0);
		send_header();
		// checksum field full of digits
		make_standard_header(SIZE_W'(5));
		put_field(CSUM_AT, CSUM_LEN, SIZE_W'(header_sum()), 0, 8, NUL);
		send_header();
		fill_random();
		put_field(CSUM_AT, CSUM_LEN, '1, 0, 8, NUL);
		send_header();
	endtask

	task automatic test_random_headers(int count);
		int pick;
		for (int n = 0; n < count; n++) begin
			sender_idle   = (n % 12) < 9;
			receiver_idle = (n % 10) < 7;
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				make_wellformed_header();
			end else if (pick < 85) begin
				make_wellformed_header();
				break_field();
			end else begin
				fill_random();
			end
			send_header();
		end
	endtask

	// result held long enough that a later header's last request stalls
	task automatic test_result_backpressure();
		sender_idle     = 1'b0;
		receiver_idle   = 1'b0;
		hold_off_cycles = 3 * HDR_BYTES - 200;
		for (int n = 0; n < 3; n++) begin
			make_wellformed_header();
			send_header();
		end
	endtask

	task automatic test_full_rate_stream();
		sender_idle   = 1'b0;
		receiver_idle = 1'b0;
		for (int n = 0; n < 6; n++) begin
			make_wellformed_header();
			send_header();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		clear_header_state();
		in_valid <= 1'b0;
		hdr_byte <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_headers();
		test_random_headers(48);
		test_result_backpressure();
		test_full_rate_stream();
		in_valid <= 1'b0;

		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/tarhc_pkg.sv
rtl/tarhc_scan.sv
rtl/tar_header_checker.sv
tb/sv/tar_header_checker_test.sv
